// ===== design/fpos_pkg.sv =====
package fpos_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int DATA_W    = 32;
   localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int SIZE_W    = 11;

   localparam logic [DATA_W-1:0] SIGN_BIAS = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_value;
      logic                     last_item;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] min_value;
      logic signed [DATA_W-1:0] p25_value;
      logic signed [DATA_W-1:0] median_value;
      logic signed [DATA_W-1:0] p75_value;
      logic signed [DATA_W-1:0] max_value;
      logic [SIZE_W-1:0]        set_size;
      logic                     overflow;
   } rsp_type;

   // broadcast to every cell of the sorting row
   typedef struct packed {
      logic              insert;
      logic              shift;
      logic [DATA_W-1:0] key;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_REPORT
   } state_type;

endpackage

// ===== design/fpos_cell.sv =====
module fpos_cell (
   input  logic                           clock,
   input  fpos_pkg::cell_ctrl_type        ctrl,
   input  logic                           occupied,
   input  logic                           left_gt,
   input  logic [fpos_pkg::DATA_W-1:0]    left_val,
   input  logic [fpos_pkg::DATA_W-1:0]    right_val,
   output logic [fpos_pkg::DATA_W-1:0]    val,
   output logic                           gt
);

   logic [fpos_pkg::DATA_W-1:0] val_ff;
   logic [fpos_pkg::DATA_W-1:0] val_in;

   // an empty cell ranks above every key
   assign gt  = !occupied || (val_ff > ctrl.key);
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.shift) begin
         val_in = right_val;
      end else if (ctrl.insert && gt) begin
         val_in = left_gt ? left_val : ctrl.key;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

// ===== design/fpos_chain.sv =====
module fpos_chain (
   input  logic                           clock,
   input  fpos_pkg::cell_ctrl_type        ctrl,
   input  logic [fpos_pkg::COUNT_W-1:0]   count,
   output logic [fpos_pkg::DATA_W-1:0]    head_val
);

   logic [fpos_pkg::DATA_W-1:0] val [fpos_pkg::MAX_ITEMS];
   logic                        gt  [fpos_pkg::MAX_ITEMS];

   for (genvar i = 0; i < fpos_pkg::MAX_ITEMS; i++) begin : g_cell
      logic                        occupied;
      logic                        left_gt;
      logic [fpos_pkg::DATA_W-1:0] left_val;
      logic [fpos_pkg::DATA_W-1:0] right_val;

      assign occupied = fpos_pkg::COUNT_W'(i) < count;

      if (i == 0) begin : g_first
         assign left_gt  = 1'b0;
         assign left_val = ctrl.key;
      end else begin : g_inner
         assign left_gt  = gt[i-1];
         assign left_val = val[i-1];
      end

      if (i == fpos_pkg::MAX_ITEMS - 1) begin : g_last
         assign right_val = val[i];
      end else begin : g_body
         assign right_val = val[i+1];
      end

      fpos_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied),
         .left_gt   (left_gt),
         .left_val  (left_val),
         .right_val (right_val),
         .val       (val[i]),
         .gt        (gt[i])
      );
   end

   assign head_val = val[0];

endmodule

// ===== design/five_point_order_statistics_core.sv =====
// Streams a set of signed 32-bit words into a row of sorting cells, one word per clock
// while busy is low; each word is inserted in order as it arrives. The word flagged
// last_item closes the set: busy then stays high while the row of kept words (at most
// 1024) shifts out through its head cell and the five order statistics are picked off,
// and rsp_strobe marks the result for exactly one cycle at the end. Words beyond 1024
// are dropped and reported through overflow. The receiver cannot stall the result: it
// must take it in the strobe cycle.
module five_point_order_statistics_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fpos_pkg::req_type req_data,
   output logic              rsp_strobe,
   output fpos_pkg::rsp_type rsp_data
);

   fpos_pkg::state_type state_ff, state_in;

   logic [fpos_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         dropped_ff, dropped_in;
   logic [fpos_pkg::COUNT_W-1:0] n_ff, n_in;
   logic [fpos_pkg::COUNT_W-1:0] k_ff, k_in;
   fpos_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         accept;
   logic                         room;
   logic                         scan_done;
   logic                         shift;
   logic [fpos_pkg::COUNT_W-1:0] mid_idx, p25_idx, p75_idx, max_idx;
   logic [fpos_pkg::DATA_W-1:0]  head_val;
   logic signed [fpos_pkg::DATA_W-1:0] head_signed;
   fpos_pkg::cell_ctrl_type      ctrl;

   assign accept      = start && !busy;
   assign room        = count_ff != fpos_pkg::COUNT_W'(fpos_pkg::MAX_ITEMS);
   assign scan_done   = k_ff == max_idx;
   assign head_signed = head_val ^ fpos_pkg::SIGN_BIAS;

   assign mid_idx = n_ff >> 1;
   assign p25_idx = mid_idx >> 1;
   assign p75_idx = mid_idx + ((n_ff - mid_idx) >> 1);
   assign max_idx = n_ff - fpos_pkg::COUNT_W'(1);

   assign ctrl.insert = accept && room;
   assign ctrl.shift  = shift;
   assign ctrl.key    = req_data.sample_value ^ fpos_pkg::SIGN_BIAS;

   fpos_chain u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .count    (count_ff),
      .head_val (head_val)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpos_pkg::ST_LOAD: begin
            if (accept && req_data.last_item) begin
               state_in = fpos_pkg::ST_SCAN;
            end
         end
         fpos_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = fpos_pkg::ST_REPORT;
            end
         end
         fpos_pkg::ST_REPORT: begin
            state_in = fpos_pkg::ST_LOAD;
         end
         default: begin
            state_in = fpos_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      shift      = 1'b0;
      rsp_strobe = 1'b0;
      case (state_ff)
         fpos_pkg::ST_LOAD: begin
            busy = 1'b0;
         end
         fpos_pkg::ST_SCAN: begin
            shift = 1'b1;
         end
         fpos_pkg::ST_REPORT: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      rsp_in     = rsp_ff;
      if (accept) begin
         if (room) begin
            count_in = count_ff + fpos_pkg::COUNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
         if (req_data.last_item) begin
            n_in            = count_in;
            k_in            = '0;
            rsp_in.set_size = fpos_pkg::SIZE_W'(count_in);
            rsp_in.overflow = dropped_in;
         end
      end
      if (shift) begin
         k_in = k_ff + fpos_pkg::COUNT_W'(1);
         if (k_ff == '0) begin
            rsp_in.min_value = head_signed;
         end
         if (k_ff == p25_idx) begin
            rsp_in.p25_value = head_signed;
         end
         if (k_ff == mid_idx) begin
            rsp_in.median_value = head_signed;
         end
         if (k_ff == p75_idx) begin
            rsp_in.p75_value = head_signed;
         end
         if (scan_done) begin
            rsp_in.max_value = head_signed;
         end
      end
      if (rsp_strobe) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fpos_pkg::ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         n_ff       <= '0;
         k_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         n_ff       <= n_in;
         k_ff       <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== design/fpos_checker.sv =====
module fpos_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input fpos_pkg::req_type req_data,
   input logic              rsp_strobe,
   input fpos_pkg::rsp_type rsp_data
);

   // closing word locks out input until the result is out
   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.last_item |=> busy)
      else $error("no busy after closing word");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result while idle");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("result not single or block stays busy");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.min_value <= rsp_data.p25_value
                  && rsp_data.p25_value <= rsp_data.median_value
                  && rsp_data.median_value <= rsp_data.p75_value
                  && rsp_data.p75_value <= rsp_data.max_value)
      else $error("statistics out of order");

   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.set_size != '0)
      else $error("empty set reported");

endmodule

bind five_point_order_statistics_core fpos_checker u_fpos_checker (.*);

// ===== tb/five_point_order_statistics_checker.sv =====
`timescale 1ns / 1ps

module five_point_order_statistics_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  fpos_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  fpos_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import fpos_pkg::*;

   // words of the open set, kept in ascending order as they arrive
   logic signed [DATA_W-1:0] sorted_words [MAX_ITEMS];
   int                       kept_count;
   logic                     words_dropped;
   rsp_type                  expected_stats [$];

   task automatic insert_word(input logic signed [DATA_W-1:0] word);
      int pos;
      if (kept_count < MAX_ITEMS) begin
         pos = kept_count;
         while (pos > 0 && sorted_words[pos-1] > word) begin
            sorted_words[pos] = sorted_words[pos-1];
            pos--;
         end
         sorted_words[pos] = word;
         kept_count++;
      end else begin
         words_dropped = 1'b1;
      end
   endtask

   task automatic close_set();
      rsp_type stats;
      int      mid;
      mid                = kept_count / 2;
      stats.min_value    = sorted_words[0];
      stats.p25_value    = sorted_words[mid / 2];
      stats.median_value = sorted_words[mid];
      stats.p75_value    = sorted_words[mid + (kept_count - mid) / 2];
      stats.max_value    = sorted_words[kept_count - 1];
      stats.set_size     = SIZE_W'(kept_count);
      stats.overflow     = words_dropped;
      expected_stats     = {expected_stats, stats};
      kept_count    = 0;
      words_dropped = 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type stats;
      logic    bad;
      if (reset) begin
         kept_count    = 0;
         words_dropped = 1'b0;
         expected_stats.delete();
         fail_count <= 0;
      end else begin
         // a result never belongs to a word taken at the same edge
         if (rsp_strobe) begin
            if (expected_stats.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected: min %0d p25 %0d med %0d p75 %0d max %0d n %0d ovf %0b",
                           rsp_data.min_value, rsp_data.p25_value, rsp_data.median_value,
                           rsp_data.p75_value, rsp_data.max_value, rsp_data.set_size,
                           rsp_data.overflow);
            end else begin
               stats = expected_stats.pop_front();
               bad   = (rsp_data.min_value    !== stats.min_value)    ||
                       (rsp_data.p25_value    !== stats.p25_value)    ||
                       (rsp_data.median_value !== stats.median_value) ||
                       (rsp_data.p75_value    !== stats.p75_value)    ||
                       (rsp_data.max_value    !== stats.max_value)    ||
                       (rsp_data.set_size     !== stats.set_size)     ||
                       (rsp_data.overflow     !== stats.overflow);
               if (bad) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) begin
                     $display("expected: min %0d p25 %0d med %0d p75 %0d max %0d n %0d ovf %0b",
                              stats.min_value, stats.p25_value, stats.median_value,
                              stats.p75_value, stats.max_value, stats.set_size, stats.overflow);
                     $display("actual:   min %0d p25 %0d med %0d p75 %0d max %0d n %0d ovf %0b",
                              rsp_data.min_value, rsp_data.p25_value, rsp_data.median_value,
                              rsp_data.p75_value, rsp_data.max_value, rsp_data.set_size,
                              rsp_data.overflow);
                  end
               end
            end
         end
         if (start && !busy) begin
            insert_word(req_data.sample_value);
            if (req_data.last_item)
               close_set();
         end
      end
      pending_count <= expected_stats.size();
   end

endmodule

// ===== tb/tb_five_point_order_statistics_core.sv =====
`timescale 1ns / 1ps

module tb_five_point_order_statistics_core;
   import fpos_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SET_WORDS   = 500;

   typedef enum int {
      VAL_FULL,
      VAL_POOL,
      VAL_EXTREME,
      VAL_MIXED
   } value_mode_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count = 0;
   int      gap_limit;
   int      words_sent;

   logic signed [DATA_W-1:0] pattern [$];

   always #1 clock = ~clock;

   five_point_order_statistics_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   five_point_order_statistics_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("five_point_order_statistics_core regression: fail");
         $finish;
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value(input value_mode_type mode);
      value_mode_type m;
      m = mode;
      if (m == VAL_MIXED)
         m = value_mode_type'($urandom_range(0, 2));
      case (m)
         VAL_POOL:    return $signed($urandom_range(0, 6)) - 3;
         VAL_EXTREME: begin
            case ($urandom_range(0, 3))
               0:       return {1'b1, {(DATA_W-1){1'b0}}};
               1:       return {1'b0, {(DATA_W-1){1'b1}}};
               2:       return '0;
               default: return '1;
            endcase
         end
         default:     return $urandom;
      endcase
   endfunction

   // start stays high across back-to-back words
   task automatic send_word(input logic signed [DATA_W-1:0] value, input logic last);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start                 <= 1'b1;
      req_data.sample_value <= value;
      req_data.last_item    <= last;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic send_set(input int size, input value_mode_type mode);
      for (int i = 0; i < size; i++)
         send_word(pick_value(mode), i == size - 1);
   endtask

   task automatic send_pattern();
      for (int i = 0; i < pattern.size(); i++)
         send_word(pattern[i], i == pattern.size() - 1);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      int             size;
      value_mode_type mode;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      gap_limit  = 16;
      words_sent = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sets: single words at both extremes, duplicates, mixed signs
      pattern = '{32'sh7fffffff};
      send_pattern();
      pattern = '{32'sh80000000};
      send_pattern();
      pattern = '{32'sh7fffffff, 32'sh80000000};
      send_pattern();
      pattern = '{32'sh00000000, 32'shffffffff, 32'sh00000001};
      send_pattern();
      pattern = '{32'sd5, 32'sd5, 32'sd5, 32'sd5};
      send_pattern();
      pattern = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'shffffffff, 32'sh1};
      send_pattern();
      wait_drained();
      gap_limit = 0;
      pattern = '{32'sd7, 32'sd6, 32'sd5, 32'sd4, -32'sd3, -32'sd2, -32'sd1, 32'sd0};
      send_pattern();

      // full store, then words dropped including the closing word
      gap_limit = 2;
      send_set(MAX_ITEMS, VAL_FULL);
      send_set(MAX_ITEMS + 1, VAL_POOL);
      send_set(MAX_ITEMS + 6, VAL_MIXED);
      wait_drained();

      words_sent = 0;
      while (words_sent < SET_WORDS) begin
         size      = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 64)
                                                 : $urandom_range(1, 20);
         gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 16;
         mode      = value_mode_type'($urandom_range(0, 3));
         send_set(size, mode);
         if ($urandom_range(0, 7) == 0)
            wait_drained();
      end
      start <= 1'b0;

      wait_drained();
      repeat (64) @(posedge clock);
      if (fail_count == 0)
         $display("five_point_order_statistics_core regression: pass");
      else
         $display("five_point_order_statistics_core regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
design/fpos_pkg.sv
design/fpos_cell.sv
design/fpos_chain.sv
design/five_point_order_statistics_core.sv
design/fpos_checker.sv
tb/five_point_order_statistics_checker.sv
tb/tb_five_point_order_statistics_core.sv
